// ===== sv/tmr_pkg.sv =====
// ---------------------------------------------------------------------------
// tmr_pkg: shared types and constants
// Command and status codes, sequencer states and the result word layout for
// the timestamp merge/replay block.
// ---------------------------------------------------------------------------
`default_nettype none

package tmr_pkg;

  // default sizes
  localparam int NUM_LANES_DEF  = 8;
  localparam int LANE_DEPTH_DEF = 1024;

  // fixed field widths
  localparam int CMD_W  = 3;
  localparam int LANE_W = 3;
  localparam int TIME_W = 64;
  localparam int STEP_W = 6;
  localparam int IDX_W  = 11;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND = 3'd0,
    CMD_CLEAR  = 3'd1,
    CMD_SEEK   = 3'd2,
    CMD_FWD    = 3'd3,
    CMD_BWD    = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    ST_DONE      = 3'd0,
    ST_EMIT      = 3'd1,
    ST_EXHAUSTED = 3'd2,
    ST_FULL      = 3'd3,
    ST_ORDER     = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_APP_RD,
    S_APP_CHK,
    S_SEEK_INIT,
    S_SEEK_CHK,
    S_SEEK_CMP,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_STEP,
    S_OUT
  } state_e;

  // one result word (replay time comes straight from the time register)
  typedef struct packed {
    status_e             status;
    logic [LANE_W-1:0]   lane;
    logic [IDX_W-1:0]    index;
    logic [TIME_W-1:0]   etime;
    logic [IDX_W-1:0]    moved;
    logic                last;
  } res_t;

endpackage

`default_nettype wire

// ===== sv/tmr_ram.sv =====
// ---------------------------------------------------------------------------
// tmr_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ---------------------------------------------------------------------------
`default_nettype none

module tmr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8192
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== sv/timestamp_merge_replay_top.sv =====
// ---------------------------------------------------------------------------
// timestamp_merge_replay_top: per-lane timestamp store with k-way replay
// Appends ordered timestamps per lane, seeks all lanes to a target time and
// steps forward or backward through the merged event order.
// ---------------------------------------------------------------------------
// One command is taken at a time; in_ready_o is low until its last result
// word has been taken. The timestamp store is a single RAM with one read
// port, and a small sequencer drives every access through it. Seek runs a
// binary search per lane, with one RAM probe per search step. Each step
// scans the lane heads, reading the head of every lane with a candidate,
// and emits one result word. No clearing pass after reset: only slots
// below a lane's count are ever read.
`default_nettype none

module timestamp_merge_replay_top #(
  parameter int NUM_LANES  = tmr_pkg::NUM_LANES_DEF,
  parameter int LANE_DEPTH = tmr_pkg::LANE_DEPTH_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output      logic        in_ready_o,
  input  wire logic [2:0]  command_i,
  input  wire logic [2:0]  lane_i,
  input  wire logic [63:0] timestamp_i,
  input  wire logic [5:0]  step_count_i,
  output      logic        out_valid_o,
  input  wire logic        out_ready_i,
  output      logic [2:0]  status_o,
  output      logic [2:0]  event_lane_o,
  output      logic [10:0] event_index_o,
  output      logic [63:0] event_time_o,
  output      logic [63:0] replay_time_o,
  output      logic [10:0] moved_o,
  output      logic        last_o
);

  localparam int LW = $clog2(NUM_LANES);
  localparam int IW = $clog2(LANE_DEPTH);
  localparam int CW = $clog2(LANE_DEPTH + 1);
  localparam int AW = LW + IW;
  localparam int RAM_DEPTH = NUM_LANES << IW;

  // sequencer and datapath registers
  tmr_pkg::state_e   state_q, state_d;
  tmr_pkg::cmd_e     cmd_q, cmd_d;
  logic [2:0]        lane_q, lane_d;
  logic [63:0]       ts_q, ts_d;
  logic [5:0]        n_q, n_d;
  logic [5:0]        done_q, done_d;
  logic [LW-1:0]     lane_idx_q, lane_idx_d;
  logic [CW-1:0]     lo_q, lo_d, hi_q, hi_d;
  logic              found_q, found_d;
  logic [LW-1:0]     best_q, best_d;
  logic [63:0]       bt_q, bt_d;
  logic              cont_q, cont_d;
  tmr_pkg::res_t     res_q, res_d;
  logic [63:0]       cur_time_q, cur_time_d;
  logic [CW-1:0]     cnt_q [NUM_LANES];
  logic [CW-1:0]     pos_q [NUM_LANES];

  // strobes
  logic              clr;
  logic              cnt_we;
  logic [CW-1:0]     cnt_wval;
  logic              pos_we;
  logic [LW-1:0]     pos_wlane;
  logic [CW-1:0]     pos_wval;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [63:0]       ram_rdata;

  // shared read of count and position
  logic [LW-1:0]     rd_lane;
  logic [CW-1:0]     cnt_rd, pos_rd;
  logic [CW-1:0]     mid;
  logic              lane_last;

  tmr_ram #(
    .WIDTH (64),
    .DEPTH (RAM_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ts_q),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // lane selected for the count/position read
  always_comb begin
    case (state_q)
      tmr_pkg::S_IDLE:                     rd_lane = LW'(lane_i);
      tmr_pkg::S_APP_RD, tmr_pkg::S_APP_CHK: rd_lane = LW'(lane_q);
      tmr_pkg::S_STEP:                     rd_lane = best_q;
      default:                             rd_lane = lane_idx_q;
    endcase
  end

  assign cnt_rd    = cnt_q[rd_lane];
  assign pos_rd    = pos_q[rd_lane];
  assign mid       = lo_q + ((hi_q - lo_q) >> 1);
  assign lane_last = (lane_idx_q == LW'(NUM_LANES - 1));

  // next state and sequencer outputs
  always_comb begin
    logic          fwd;
    logic          ok;
    logic [CW-1:0] idx;
    logic          better;
    logic [5:0]    done_n;
    state_d    = state_q;
    cmd_d      = cmd_q;
    lane_d     = lane_q;
    ts_d       = ts_q;
    n_d        = n_q;
    done_d     = done_q;
    lane_idx_d = lane_idx_q;
    lo_d       = lo_q;
    hi_d       = hi_q;
    found_d    = found_q;
    best_d     = best_q;
    bt_d       = bt_q;
    cont_d     = cont_q;
    res_d      = res_q;
    cur_time_d = cur_time_q;
    clr        = 1'b0;
    cnt_we     = 1'b0;
    cnt_wval   = cnt_rd;
    pos_we     = 1'b0;
    pos_wlane  = rd_lane;
    pos_wval   = pos_rd;
    ram_we     = 1'b0;
    ram_waddr  = {rd_lane, IW'(cnt_rd)};
    ram_raddr  = '0;
    fwd        = (cmd_q == tmr_pkg::CMD_FWD);
    ok         = 1'b0;
    idx        = pos_rd;
    better     = 1'b0;
    done_n     = done_q + 6'd1;

    case (state_q)
      tmr_pkg::S_IDLE: begin
        if (in_valid_i) begin
          cmd_d      = tmr_pkg::cmd_e'(command_i);
          lane_d     = lane_i;
          ts_d       = timestamp_i;
          n_d        = step_count_i;
          done_d     = '0;
          lane_idx_d = '0;
          found_d    = 1'b0;
          cont_d     = 1'b0;
          res_d      = '{tmr_pkg::ST_DONE, 3'd0, 11'd0, 64'd0, 11'd0, 1'b1};
          state_d    = tmr_pkg::S_OUT;
          case (tmr_pkg::cmd_e'(command_i))
            tmr_pkg::CMD_APPEND: begin
              if ({29'd0, lane_i} >= 32'(NUM_LANES)) begin
                res_d.status = tmr_pkg::ST_FULL;
              end else if (cnt_rd == CW'(LANE_DEPTH)) begin
                res_d = '{tmr_pkg::ST_FULL, lane_i, 11'(cnt_rd), timestamp_i,
                          11'(cnt_rd), 1'b1};
              end else if (cnt_rd == '0) begin
                // empty lane: nothing to order against
                state_d = tmr_pkg::S_APP_CHK;
              end else begin
                state_d = tmr_pkg::S_APP_RD;
              end
            end
            tmr_pkg::CMD_CLEAR: clr = 1'b1;
            tmr_pkg::CMD_SEEK:  state_d = tmr_pkg::S_SEEK_INIT;
            tmr_pkg::CMD_FWD, tmr_pkg::CMD_BWD: begin
              if (step_count_i != '0) state_d = tmr_pkg::S_SCAN_RD;
            end
            default: ;
          endcase
        end
      end

      // fetch the lane's last timestamp
      tmr_pkg::S_APP_RD: begin
        ram_raddr = {LW'(lane_q), IW'(cnt_rd - CW'(1))};
        state_d   = tmr_pkg::S_APP_CHK;
      end

      tmr_pkg::S_APP_CHK: begin
        state_d = tmr_pkg::S_OUT;
        if (cnt_rd != '0 && ts_q < ram_rdata) begin
          res_d = '{tmr_pkg::ST_ORDER, lane_q, 11'(cnt_rd), ts_q, 11'(cnt_rd), 1'b1};
        end else begin
          ram_we   = 1'b1;
          cnt_we   = 1'b1;
          cnt_wval = cnt_rd + CW'(1);
          res_d    = '{tmr_pkg::ST_DONE, lane_q, 11'(cnt_rd), ts_q,
                       11'(cnt_rd + CW'(1)), 1'b1};
        end
      end

      // binary search per lane
      tmr_pkg::S_SEEK_INIT: begin
        lo_d    = '0;
        hi_d    = cnt_rd;
        state_d = tmr_pkg::S_SEEK_CHK;
      end

      tmr_pkg::S_SEEK_CHK: begin
        if (lo_q < hi_q) begin
          ram_raddr = {lane_idx_q, IW'(mid)};
          state_d   = tmr_pkg::S_SEEK_CMP;
        end else begin
          pos_we   = 1'b1;
          pos_wval = lo_q;
          if (lane_last) begin
            cur_time_d = ts_q;
            state_d    = tmr_pkg::S_OUT;
          end else begin
            lane_idx_d = lane_idx_q + LW'(1);
            state_d    = tmr_pkg::S_SEEK_INIT;
          end
        end
      end

      tmr_pkg::S_SEEK_CMP: begin
        if (ram_rdata < ts_q) lo_d = mid + CW'(1);
        else                  hi_d = mid;
        state_d = tmr_pkg::S_SEEK_CHK;
      end

      // scan lane heads for the next candidate
      tmr_pkg::S_SCAN_RD: begin
        if (fwd) begin
          ok  = (pos_rd < cnt_rd);
          idx = pos_rd;
        end else begin
          ok  = (pos_rd != '0) && (pos_rd <= cnt_rd);
          idx = pos_rd - CW'(1);
        end
        ram_raddr = {lane_idx_q, IW'(idx)};
        if (ok) begin
          state_d = tmr_pkg::S_SCAN_CMP;
        end else if (lane_last) begin
          state_d = tmr_pkg::S_STEP;
        end else begin
          lane_idx_d = lane_idx_q + LW'(1);
        end
      end

      tmr_pkg::S_SCAN_CMP: begin
        better = !found_q || (fwd ? (ram_rdata < bt_q) : (ram_rdata > bt_q));
        if (better) begin
          found_d = 1'b1;
          bt_d    = ram_rdata;
          best_d  = lane_idx_q;
        end
        if (lane_last) begin
          state_d = tmr_pkg::S_STEP;
        end else begin
          lane_idx_d = lane_idx_q + LW'(1);
          state_d    = tmr_pkg::S_SCAN_RD;
        end
      end

      // move the winning lane and emit
      tmr_pkg::S_STEP: begin
        state_d = tmr_pkg::S_OUT;
        if (!found_q) begin
          cont_d = 1'b0;
          res_d  = '{tmr_pkg::ST_EXHAUSTED, 3'd0, 11'd0, 64'd0, 11'(done_q), 1'b1};
        end else begin
          idx      = fwd ? pos_rd : pos_rd - CW'(1);
          pos_we   = 1'b1;
          pos_wval = fwd ? pos_rd + CW'(1) : idx;
          cur_time_d = bt_q;
          done_d   = done_n;
          cont_d   = (done_n != n_q);
          res_d    = '{tmr_pkg::ST_EMIT, 3'(best_q), 11'(idx), bt_q, 11'(done_n),
                       done_n == n_q};
        end
      end

      tmr_pkg::S_OUT: begin
        if (out_ready_i) begin
          if (cont_q) begin
            lane_idx_d = '0;
            found_d    = 1'b0;
            state_d    = tmr_pkg::S_SCAN_RD;
          end else begin
            state_d    = tmr_pkg::S_IDLE;
          end
        end
      end

      default: state_d = tmr_pkg::S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tmr_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // control state: replay time, lane counts and positions
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_time_q <= '0;
      for (int i = 0; i < NUM_LANES; i++) begin
        cnt_q[i] <= '0;
        pos_q[i] <= '0;
      end
    end else begin
      cur_time_q <= cur_time_d;
      if (clr) begin
        for (int i = 0; i < NUM_LANES; i++) begin
          cnt_q[i] <= '0;
          pos_q[i] <= '0;
        end
      end else begin
        if (cnt_we) cnt_q[rd_lane] <= cnt_wval;
        if (pos_we) pos_q[pos_wlane] <= pos_wval;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    lane_q     <= lane_d;
    ts_q       <= ts_d;
    n_q        <= n_d;
    done_q     <= done_d;
    lane_idx_q <= lane_idx_d;
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    found_q    <= found_d;
    best_q     <= best_d;
    bt_q       <= bt_d;
    cont_q     <= cont_d;
    res_q      <= res_d;
  end

  // ports
  assign in_ready_o    = (state_q == tmr_pkg::S_IDLE);
  assign out_valid_o   = (state_q == tmr_pkg::S_OUT);
  assign status_o      = res_q.status;
  assign event_lane_o  = res_q.lane;
  assign event_index_o = res_q.index;
  assign event_time_o  = res_q.etime;
  assign replay_time_o = cur_time_q;
  assign moved_o       = res_q.moved;
  assign last_o        = res_q.last;

endmodule

`default_nettype wire

// ===== sv/tmr_chk.sv =====
// ---------------------------------------------------------------------------
// tmr_chk: port-level checks for the timestamp merge/replay block
// Watches the two handshakes and the result words over time.
// ---------------------------------------------------------------------------
`default_nettype none

module tmr_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic [2:0]  command_i,
  input wire logic [2:0]  lane_i,
  input wire logic [63:0] timestamp_i,
  input wire logic [5:0]  step_count_i,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [2:0]  status_o,
  input wire logic [2:0]  event_lane_o,
  input wire logic [10:0] event_index_o,
  input wire logic [63:0] event_time_o,
  input wire logic [63:0] replay_time_o,
  input wire logic [10:0] moved_o,
  input wire logic        last_o
);

  // a command is never taken while a word is pending
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready while a result word is pending");

  // a stalled word holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o)
      && $stable(event_time_o) && $stable(moved_o) && $stable(last_o))
    else $error("result word changed while stalled");

  // running out of events always ends the command
  a_exhaust_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == tmr_pkg::ST_EXHAUSTED |-> last_o)
    else $error("exhausted word without last");

  // after the final word the block is ready again
  a_ready_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && last_o |=> in_ready_o)
    else $error("not ready after final word");

  // an emitted word reports the replay time it moved to
  a_emit_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == tmr_pkg::ST_EMIT |-> replay_time_o == event_time_o)
    else $error("replay time differs from emitted event");

endmodule

bind timestamp_merge_replay_top tmr_chk u_tmr_chk (.*);

`default_nettype wire
